// ----- hdl/mlpd_pkg.sv -----
// Package for the magic length-prefixed deframer: shared constants, error codes,
// register indexes and the result item type.
// No dependencies.
package mlpd_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned HDR_BYTES    = 8;
  localparam int unsigned MAGIC_W      = 32;
  localparam int unsigned HDR_SIZE_W   = 32;
  localparam int unsigned MAX_SIZE_W   = 24;
  localparam int unsigned SIZE_WIDTH_DEF = 24;
  localparam int unsigned HDR_CNT_W    = 3;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [HDR_CNT_W-1:0]  HDR_LAST      = HDR_CNT_W'(HDR_BYTES - 1);
  localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RST  = '1;
  localparam logic [HDR_SIZE_W-1:0] HDR_BYTES_SZ  = HDR_SIZE_W'(HDR_BYTES);

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_MAGIC = 2'd1,
    ERR_SMALL = 2'd2,
    ERR_LARGE = 2'd3
  } frame_err_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              byte_present;
    logic              last_of_message;
    frame_err_t        frame_error;
  } result_t;

endpackage

// ----- hdl/magic_length_prefixed_deframer_top.sv -----
// Top level of the magic length-prefixed deframer: stream ports, input and
// output registers, configuration registers. Depends on mlpd_pkg, mlpd_core.
//
// Takes a byte stream, one byte per item, and splits it into messages. Each
// message opens with an 8-byte header: a 32-bit little-endian magic word and a
// 32-bit little-endian total size that counts the header. Header bytes give no
// output item; each of the size-8 payload bytes that follow comes out as one
// item, the final one with tlast set. A size of exactly 8 gives one empty item
// (tuser byte_present low, tlast high). A wrong magic, a size below 8 or a size
// above min(size cap register, 2^SIZE_WIDTH-1) gives one error item and the
// next byte starts a new header. Rate: one byte per cycle while out_tready is
// high; out_tready low stalls the input. A byte waits in the input register;
// when it advances, the state update loads its result, if any, into the
// output register. The user must write configuration through cfg_wr_en/
// cfg_index/cfg_wdata while the stream is idle (not enforced by the block);
// index 0 is the magic word, index 1 is the size cap, other indexes are ignored.
module magic_length_prefixed_deframer_top
  import mlpd_pkg::*;
#(
  parameter int unsigned SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] stream_byte
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BYTE_W-1:0]     out_tdata,  // [7:0] payload_byte
  output logic                  out_tlast,  // last_of_message
  output logic [2:0]            out_tuser,  // [0] byte_present, [2:1] frame_error
  // configuration writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                  in_valid_r;
  logic [BYTE_W-1:0]     in_byte_r;
  logic                  advance;

  logic [MAGIC_W-1:0]    magic_word_r;
  logic [MAX_SIZE_W-1:0] max_size_r;

  logic                  res_valid;
  result_t               res;

  logic                  out_valid_r, out_valid_nxt;
  result_t               out_res_r;

  // the held byte moves on once the output register is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r <= '0;
      max_size_r   <= MAX_SIZE_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_MAGIC_WORD) begin
        magic_word_r <= cfg_wdata[MAGIC_W-1:0];
      end else if (cfg_index == CFG_MAX_SIZE) begin
        max_size_r <= cfg_wdata[MAX_SIZE_W-1:0];
      end
    end
  end

  mlpd_core #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .step_byte  (in_byte_r),
    .magic_word (magic_word_r),
    .size_cap   (max_size_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // header bytes advance without loading the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.payload_byte;
  assign out_tlast  = out_res_r.last_of_message;
  assign out_tuser  = {out_res_r.frame_error, out_res_r.byte_present};

endmodule

// ----- hdl/mlpd_core.sv -----
// Deframer state machine: header collection, header checks and payload count.
// Produces at most one result per stepped byte. Depends on mlpd_pkg.
module mlpd_core
  import mlpd_pkg::*;
#(
  parameter int unsigned SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [BYTE_W-1:0]     step_byte,
  input  logic [MAGIC_W-1:0]    magic_word,
  input  logic [MAX_SIZE_W-1:0] size_cap,
  output logic                  res_valid,
  output result_t               res
);

  localparam logic [HDR_SIZE_W-1:0] SIZE_MASK =
    HDR_SIZE_W'((64'd1 << SIZE_WIDTH) - 64'd1);

  logic [HDR_BYTES-2:0][BYTE_W-1:0] hdr_r, hdr_nxt;
  logic [HDR_CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [SIZE_WIDTH-1:0]            rem_r, rem_nxt;
  logic                             in_payload_r, in_payload_nxt;

  logic [HDR_BYTES*BYTE_W-1:0] full_hdr;
  logic [MAGIC_W-1:0]          hdr_magic;
  logic [HDR_SIZE_W-1:0]       hdr_size;
  logic [SIZE_WIDTH-1:0]       rem_dec;

  assign full_hdr  = {step_byte, hdr_r};
  assign hdr_magic = full_hdr[MAGIC_W-1:0];
  assign hdr_size  = full_hdr[MAGIC_W +: HDR_SIZE_W];
  assign rem_dec   = rem_r - SIZE_WIDTH'(1);

  always_comb begin
    hdr_nxt        = hdr_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    in_payload_nxt = in_payload_r;
    res_valid      = 1'b0;
    res            = '{payload_byte: '0, byte_present: 1'b0,
                       last_of_message: 1'b0, frame_error: ERR_NONE};
    if (step_en) begin
      if (in_payload_r) begin
        rem_nxt              = rem_dec;
        res_valid            = 1'b1;
        res.payload_byte     = step_byte;
        res.byte_present     = 1'b1;
        res.last_of_message  = (rem_dec == '0);
        if (rem_dec == '0) begin
          in_payload_nxt = 1'b0;
        end
      end else if (cnt_r != HDR_LAST) begin
        hdr_nxt[cnt_r] = step_byte;
        cnt_nxt        = cnt_r + HDR_CNT_W'(1);
      end else begin
        // full header in hand: check in order magic, too small, too large
        cnt_nxt   = '0;
        res_valid = 1'b1;
        if (hdr_magic != magic_word) begin
          res.frame_error = ERR_MAGIC;
        end else if (hdr_size < HDR_BYTES_SZ) begin
          res.frame_error = ERR_SMALL;
        end else if (hdr_size > HDR_SIZE_W'(size_cap) || hdr_size > SIZE_MASK) begin
          res.frame_error = ERR_LARGE;
        end else if (hdr_size == HDR_BYTES_SZ) begin
          res.last_of_message = 1'b1;
        end else begin
          res_valid      = 1'b0;
          rem_nxt        = SIZE_WIDTH'(hdr_size - HDR_BYTES_SZ);
          in_payload_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    if (!rst_n) begin
      cnt_r        <= '0;
      rem_r        <= '0;
      in_payload_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      rem_r        <= rem_nxt;
      in_payload_r <= in_payload_nxt;
    end
  end

endmodule
